// ===== rtl/core/swm_pkg.sv =====
// Shared types and constants of the sliding-window median filter.
package swm_pkg;

    // Width and reset value of the window size register
    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd3;

    // Control handed from a cell to its right neighbor
    typedef struct packed {
        logic cmp;       // cell value is above the new sample, or cell is empty
        logic del_seen;  // the leaving sample sits in this cell or one to its left
    } link_t;

endpackage

// ===== rtl/core/swm_cell.sv =====
// One cell of the sorted window: holds a sample, its age and a valid bit.
module swm_cell #(
    parameter int SAMPLE_BITS = 32,
    parameter int AGE_W       = 5,
    parameter int CNT_W       = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  logic                          clear,
    input  logic                          start,
    input  logic                          full,
    input  logic        [CNT_W-1:0]       w_m1,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    // left neighbor
    input  swm_pkg::link_t                left_link,
    input  logic signed [SAMPLE_BITS-1:0] left_val,
    input  logic        [AGE_W-1:0]       left_age,
    input  logic                          left_valid,
    // right neighbor
    input  logic                          right_cmp,
    input  logic signed [SAMPLE_BITS-1:0] right_val,
    input  logic        [AGE_W-1:0]       right_age,
    input  logic                          right_valid,
    // own contents as seen by the neighbors
    output swm_pkg::link_t                link,
    output logic signed [SAMPLE_BITS-1:0] val,
    output logic        [AGE_W-1:0]       age,
    output logic                          valid
);
    import swm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic        [AGE_W-1:0]       age_reg, age_next;
    logic                          valid_reg, valid_next;
    logic                          del;

    // a new sequence empties the window before the sample goes in
    assign valid = valid_reg & ~start;
    assign val   = val_reg;
    assign age   = age_reg;

    // the oldest sample of a full window leaves
    assign del           = valid && full && (CNT_W'(age_reg) == w_m1);
    assign link.cmp      = ~valid | (val_reg > sample);
    assign link.del_seen = left_link.del_seen | del;

    // insert the sample and drop the leaving one in a single shift
    always_comb
    begin
        val_next   = val_reg;
        age_next   = age_reg + AGE_W'(1);
        valid_next = valid;
        if (!link.cmp)
        begin
            if (link.del_seen)
            begin
                if (!right_cmp)
                begin
                    val_next   = right_val;
                    age_next   = right_age + AGE_W'(1);
                    valid_next = right_valid;
                end
                else
                begin
                    val_next   = sample;
                    age_next   = '0;
                    valid_next = 1'b1;
                end
            end
        end
        else if (!left_link.del_seen)
        begin
            if (left_link.cmp)
            begin
                val_next   = left_val;
                age_next   = left_age + AGE_W'(1);
                valid_next = left_valid;
            end
            else
            begin
                val_next   = sample;
                age_next   = '0;
                valid_next = 1'b1;
            end
        end
    end

    // valid bit is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= valid_next;
        end
    end

    // sample and age
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

// ===== rtl/core/swm_median.sv =====
// Picks the middle pair of the sorted window and forms twice the median.
module swm_median #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 32,
    parameter int AGE_W       = 5,
    parameter int CNT_W       = 6
) (
    input  logic signed [SAMPLE_BITS-1:0] vals [MAX_WINDOW],
    input  logic        [CNT_W-1:0]       w_eff,
    output logic signed [SAMPLE_BITS:0]   median_sum
);
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] lo_cnt;
    logic [AGE_W-1:0] idx_hi;
    logic [AGE_W-1:0] idx_lo;
    logic signed [SAMPLE_BITS-1:0] hi_val;
    logic signed [SAMPLE_BITS-1:0] lo_val;

    // odd window: the middle twice; even: the two middle values
    assign half   = w_eff >> 1;
    assign lo_cnt = w_eff[0] ? half : half - CNT_W'(1);
    assign idx_hi = half[AGE_W-1:0];
    assign idx_lo = lo_cnt[AGE_W-1:0];

    assign hi_val = vals[idx_hi];
    assign lo_val = vals[idx_lo];

    assign median_sum = {hi_val[SAMPLE_BITS-1], hi_val} + {lo_val[SAMPLE_BITS-1], lo_val};

endmodule

// ===== rtl/core/sliding_window_median.sv =====
// Top level of the sliding-window median filter: cell chain, fill control, output stage.
//
// Sliding-window median filter. Signed samples enter a chain of MAX_WINDOW cells that
// keep the window in ascending order; every cell also keeps the age of its sample, so
// the oldest one leaves in the same cycle as the new one is inserted. One sample is
// taken per clock; its result is marked pending, then loaded into the output register;
// the chain stalls only while that register is full and held. Once the window holds
// window_size samples, each sample gives median_twice, twice the median (the sum of
// the two middle values for an even window). window_size 0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW. Setting start_of_sequence, or writing window_size,
// empties the window; no result comes out until it is full again.
module sliding_window_median #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample requests
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          start_of_sequence,
    // median requests
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS:0]   median_twice,
    // window size register
    input  logic                          window_size_we,
    input  logic [swm_pkg::CFG_W-1:0]     window_size_data
);
    import swm_pkg::*;

    localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [CFG_W-1:0] window_size_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] w_eff;
    logic [CNT_W-1:0] w_m1;
    logic             pend_reg;
    logic             out_valid_reg;
    logic signed [SAMPLE_BITS:0] median_reg;
    logic             out_load;
    logic             accept;
    logic             full;

    logic signed [SAMPLE_BITS-1:0] vals  [MAX_WINDOW];
    logic        [AGE_W-1:0]       ages  [MAX_WINDOW];
    logic                          valids[MAX_WINDOW];
    link_t                         links [MAX_WINDOW];
    logic signed [SAMPLE_BITS:0]   median_sum;

    // effective window size
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (int'(window_size_reg) > MAX_WINDOW)
        begin
            w_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = CNT_W'(window_size_reg);
        end
    end
    assign w_m1 = w_eff - CNT_W'(1);

    // handshake: a pending median must move out before the chain shifts again
    assign out_load = ~out_valid_reg | ~out_stall;
    assign in_stall = pend_reg & ~out_load;
    assign accept   = in_valid & ~in_stall;
    assign full     = ~start_of_sequence & (fill_reg == w_eff);

    // fill count after this sample
    always_comb
    begin
        if (start_of_sequence)
        begin
            fill_next = CNT_W'(1);
        end
        else if (full)
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    // window size, fill count and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_RESET;
            fill_reg        <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (window_size_we)
            begin
                window_size_reg <= window_size_data;
                fill_reg        <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
            end
            if (out_load)
            begin
                out_valid_reg <= pend_reg;
            end
            if (accept)
            begin
                pend_reg <= (fill_next == w_eff);
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    // output data
    always_ff @(posedge clk)
    begin
        if (out_load && pend_reg)
        begin
            median_reg <= median_sum;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_twice = median_reg;

    // chain of sorting cells
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        link_t                         l_link;
        logic signed [SAMPLE_BITS-1:0] l_val;
        logic        [AGE_W-1:0]       l_age;
        logic                          l_valid;
        logic                          r_cmp;
        logic signed [SAMPLE_BITS-1:0] r_val;
        logic        [AGE_W-1:0]       r_age;
        logic                          r_valid;

        if (i == 0)
        begin : g_left_edge
            assign l_link  = '0;
            assign l_val   = '0;
            assign l_age   = '0;
            assign l_valid = 1'b0;
        end
        else
        begin : g_left
            assign l_link  = links[i-1];
            assign l_val   = vals[i-1];
            assign l_age   = ages[i-1];
            assign l_valid = valids[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_right_edge
            assign r_cmp   = 1'b1;
            assign r_val   = '0;
            assign r_age   = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_right
            assign r_cmp   = links[i+1].cmp;
            assign r_val   = vals[i+1];
            assign r_age   = ages[i+1];
            assign r_valid = valids[i+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_W       (AGE_W),
            .CNT_W       (CNT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift_en    (accept),
            .clear       (window_size_we),
            .start       (start_of_sequence),
            .full        (full),
            .w_m1        (w_m1),
            .sample      (sample),
            .left_link   (l_link),
            .left_val    (l_val),
            .left_age    (l_age),
            .left_valid  (l_valid),
            .right_cmp   (r_cmp),
            .right_val   (r_val),
            .right_age   (r_age),
            .right_valid (r_valid),
            .link        (links[i]),
            .val         (vals[i]),
            .age         (ages[i]),
            .valid       (valids[i])
        );
    end

    // middle pair of the window
    swm_median #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AGE_W       (AGE_W),
        .CNT_W       (CNT_W)
    ) u_median (
        .vals       (vals),
        .w_eff      (w_eff),
        .median_sum (median_sum)
    );

endmodule
